/* hdl/dda_pkg.sv */
// Shared types and constants for the DDA grid ray stepper.
// No dependencies; every other file imports this package.
package dda_pkg;

  localparam int ORIGIN_W   = 24;
  localparam int DIR_W      = 16;
  localparam int MAG_W      = 16;
  localparam int CELL_OUT_W = 16;
  localparam int DIST_W     = 32;
  localparam int DIV_STEPS  = 31;

  localparam logic OP_INIT = 1'b0;
  localparam logic OP_STEP = 1'b1;

  localparam logic AXIS_X = 1'b0;
  localparam logic AXIS_Y = 1'b1;

  typedef logic        [ORIGIN_W-1:0]   origin_t;
  typedef logic signed [DIR_W-1:0]      dir_t;
  typedef logic        [MAG_W-1:0]      mag_t;
  typedef logic signed [CELL_OUT_W-1:0] cell_out_t;
  typedef logic        [DIST_W-1:0]     dist_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_FIN
  } ctrl_state_t;

  typedef struct packed {
    logic start;
    logic step;
    logic iter;
    logic mul;
    logic fin;
  } dp_cmd_t;

  typedef struct packed {
    logic item_valid;
    logic item_op;
    logic out_free;
  } ctrl_stat_t;

endpackage

/* hdl/dda_ifs.sv */
// Valid/ready channel interfaces for ray items and result words.
// Depends on dda_pkg for payload types.
interface dda_item_if;
  import dda_pkg::*;

  logic    valid;
  logic    ready;
  logic    op;
  origin_t origin_x;
  origin_t origin_y;
  dir_t    dir_x;
  dir_t    dir_y;

  modport source(output valid, op, origin_x, origin_y, dir_x, dir_y, input ready);
  modport sink(input valid, op, origin_x, origin_y, dir_x, dir_y, output ready);
endinterface

interface dda_result_if;
  import dda_pkg::*;

  logic      valid;
  logic      ready;
  cell_out_t cell_x;
  cell_out_t cell_y;
  logic      axis;
  dist_t     side_dist_x;
  dist_t     side_dist_y;

  modport source(output valid, cell_x, cell_y, axis, side_dist_x, side_dist_y,
                 input ready);
  modport sink(input valid, cell_x, cell_y, axis, side_dist_x, side_dist_y,
               output ready);
endinterface

/* hdl/dda_ctrl.sv */
// Sequencer for the ray stepper: accepts words, runs the reciprocal,
// multiply and commit phases of an init. Depends on dda_pkg.
module dda_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  dda_pkg::ctrl_stat_t stat,
  output logic                item_ready,
  output dda_pkg::dp_cmd_t    cmd
);
  import dda_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS);

  ctrl_state_t       state;
  ctrl_state_t       state_next;
  logic [CNT_W-1:0]  cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_DIV) begin
        cnt <= cnt + CNT_W'(1);
      end else begin
        cnt <= '0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (stat.item_valid && item_ready && stat.item_op == OP_INIT) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL:  state_next = ST_FIN;
      ST_FIN:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item_ready = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        item_ready = stat.out_free && !rst;
        cmd.start  = stat.item_valid && item_ready && stat.item_op == OP_INIT;
        cmd.step   = stat.item_valid && item_ready && stat.item_op == OP_STEP;
      end
      ST_DIV:  cmd.iter = 1'b1;
      ST_MUL:  cmd.mul  = 1'b1;
      ST_FIN:  cmd.fin  = 1'b1;
      default: cmd      = '0;
    endcase
  end

endmodule

/* hdl/dda_recip.sv */
// Bit-serial restoring divider: 2^30 / |dir|, one quotient bit per cycle.
// Depends on dda_pkg.
module dda_recip (
  input  logic          clk,
  input  logic          start,
  input  logic          iter,
  input  dda_pkg::dir_t dir,
  output dda_pkg::dist_t delta
);
  import dda_pkg::*;

  mag_t                 mag;
  mag_t                 rem;
  logic [DIV_STEPS-1:0] quo;
  logic                 is_zero;
  logic [DIR_W-1:0]     dir_u;
  mag_t                 dir_mag;
  logic [MAG_W:0]       trial;
  logic [MAG_W:0]       diff;
  logic                 ge;

  assign dir_u   = dir;
  assign dir_mag = dir_u[DIR_W-1] ? mag_t'(~dir_u + DIR_W'(1)) : mag_t'(dir_u);
  assign trial   = {rem, quo[DIV_STEPS-1]};
  assign ge      = trial >= {1'b0, mag};
  assign diff    = trial - {1'b0, mag};

  always_ff @(posedge clk) begin
    if (start) begin
      mag     <= dir_mag;
      rem     <= '0;
      quo     <= DIV_STEPS'(1) << (DIV_STEPS - 1);
      is_zero <= (dir_mag == '0);
    end else if (iter) begin
      rem <= ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
      quo <= {quo[DIV_STEPS-2:0], ge};
    end
  end

  assign delta = is_zero ? '1 : DIST_W'(quo);

endmodule

/* hdl/dda_datapath.sv */
// Ray state, reciprocal units, edge multipliers, step adder and result
// register. Depends on dda_pkg, dda_result_if and dda_recip.
module dda_datapath #(
  parameter int FRAC_BITS = 16,
  parameter int CELL_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  dda_pkg::dp_cmd_t cmd,
  input  dda_pkg::origin_t origin_x,
  input  dda_pkg::origin_t origin_y,
  input  dda_pkg::dir_t    dir_x,
  input  dda_pkg::dir_t    dir_y,
  output logic             out_free,
  dda_result_if.source     result
);
  import dda_pkg::*;

  localparam int EDGE_W = FRAC_BITS + 1;
  localparam int PROD_W = EDGE_W + DIST_W;

  logic [CELL_BITS-1:0] cell_x;
  logic [CELL_BITS-1:0] cell_y;
  dist_t                side_x;
  dist_t                side_y;
  dist_t                delta_x;
  dist_t                delta_y;
  logic                 step_neg_x;
  logic                 step_neg_y;

  logic [CELL_BITS-1:0] cell_x_next;
  logic [CELL_BITS-1:0] cell_y_next;
  dist_t                side_x_next;
  dist_t                side_y_next;
  dist_t                delta_x_next;
  dist_t                delta_y_next;
  logic                 step_neg_x_next;
  logic                 step_neg_y_next;
  logic                 axis_next;

  logic [EDGE_W-1:0]    edge_x;
  logic [EDGE_W-1:0]    edge_y;
  logic [PROD_W-1:0]    prod_x;
  logic [PROD_W-1:0]    prod_y;
  dist_t                recip_x;
  dist_t                recip_y;
  logic                 take_x;
  logic                 load;

  function automatic logic [CELL_BITS-1:0] cell_of(input origin_t o);
    logic [ORIGIN_W+CELL_BITS-1:0] ext;
    ext = {{CELL_BITS{1'b0}}, o};
    return ext[FRAC_BITS +: CELL_BITS];
  endfunction

  function automatic logic [EDGE_W-1:0] edge_of(input origin_t o, input logic neg);
    logic [EDGE_W-1:0] frac;
    frac = {1'b0, o[FRAC_BITS-1:0]};
    return neg ? frac : ((EDGE_W'(1) << FRAC_BITS) - frac);
  endfunction

  function automatic dist_t sat_shift(input logic [PROD_W-1:0] p);
    logic [DIST_W:0] s;
    s = p[FRAC_BITS +: DIST_W+1];
    return s[DIST_W] ? '1 : s[DIST_W-1:0];
  endfunction

  function automatic dist_t sat_add(input dist_t a, input dist_t b);
    logic [DIST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DIST_W] ? '1 : s[DIST_W-1:0];
  endfunction

  function automatic cell_out_t cell_out(input logic [CELL_BITS-1:0] c);
    logic [CELL_BITS+CELL_OUT_W-1:0] ext;
    ext = {{CELL_OUT_W{1'b0}}, c};
    return cell_out_t'(ext[CELL_OUT_W-1:0]);
  endfunction

  dda_recip u_recip_x (
    .clk   (clk),
    .start (cmd.start),
    .iter  (cmd.iter),
    .dir   (dir_x),
    .delta (recip_x)
  );

  dda_recip u_recip_y (
    .clk   (clk),
    .start (cmd.start),
    .iter  (cmd.iter),
    .dir   (dir_y),
    .delta (recip_y)
  );

  assign take_x   = side_x < side_y;
  assign load     = cmd.step || cmd.fin;
  assign out_free = !result.valid || result.ready;

  always_comb begin
    cell_x_next     = cell_x;
    cell_y_next     = cell_y;
    side_x_next     = side_x;
    side_y_next     = side_y;
    delta_x_next    = delta_x;
    delta_y_next    = delta_y;
    step_neg_x_next = step_neg_x;
    step_neg_y_next = step_neg_y;
    axis_next       = AXIS_X;
    if (cmd.start) begin
      cell_x_next     = cell_of(origin_x);
      cell_y_next     = cell_of(origin_y);
      step_neg_x_next = dir_x[DIR_W-1];
      step_neg_y_next = dir_y[DIR_W-1];
    end
    if (cmd.fin) begin
      delta_x_next = recip_x;
      delta_y_next = recip_y;
      side_x_next  = sat_shift(prod_x);
      side_y_next  = sat_shift(prod_y);
    end
    if (cmd.step) begin
      if (take_x) begin
        side_x_next = sat_add(side_x, delta_x);
        cell_x_next = step_neg_x ? cell_x - CELL_BITS'(1) : cell_x + CELL_BITS'(1);
      end else begin
        side_y_next = sat_add(side_y, delta_y);
        cell_y_next = step_neg_y ? cell_y - CELL_BITS'(1) : cell_y + CELL_BITS'(1);
        axis_next   = AXIS_Y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_x     <= '0;
      cell_y     <= '0;
      side_x     <= '0;
      side_y     <= '0;
      delta_x    <= '0;
      delta_y    <= '0;
      step_neg_x <= 1'b0;
      step_neg_y <= 1'b0;
    end else begin
      cell_x     <= cell_x_next;
      cell_y     <= cell_y_next;
      side_x     <= side_x_next;
      side_y     <= side_y_next;
      delta_x    <= delta_x_next;
      delta_y    <= delta_y_next;
      step_neg_x <= step_neg_x_next;
      step_neg_y <= step_neg_y_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      edge_x <= edge_of(origin_x, dir_x[DIR_W-1]);
      edge_y <= edge_of(origin_y, dir_y[DIR_W-1]);
    end
    if (cmd.mul) begin
      prod_x <= PROD_W'(edge_x) * PROD_W'(recip_x);
      prod_y <= PROD_W'(edge_y) * PROD_W'(recip_y);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.cell_x      <= cell_out(cell_x_next);
      result.cell_y      <= cell_out(cell_y_next);
      result.axis        <= axis_next;
      result.side_dist_x <= side_x_next;
      result.side_dist_y <= side_y_next;
    end
  end

endmodule

/* hdl/dda_grid_ray_stepper.sv */
// Top level of the DDA grid ray stepper: joins sequencer and datapath.
// Depends on dda_pkg, dda_ifs, dda_ctrl and dda_datapath.
//
//   channel  dir  payload                                        per word
//   item     in   op, origin_x, origin_y, dir_x, dir_y           one ray command
//   result   out  cell_x, cell_y, axis, side_dist_x, side_dist_y one answer
//
// Step word: result registered on acceptance; one step per cycle unless stalled.
// Init word: runs the bit-serial reciprocal (ST_DIV), the edge multiply
//   (ST_MUL) and the commit (ST_FIN) in turn; item.ready stays low meanwhile.
// Reset (rst, synchronous) clears the sequencer, ray state and result valid.
// A held result stalls intake only while it is not being taken.
module dda_grid_ray_stepper #(
  parameter int FRAC_BITS = 16,
  parameter int CELL_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  dda_item_if.sink     item,
  dda_result_if.source result
);
  import dda_pkg::*;

  ctrl_stat_t stat;
  dp_cmd_t    cmd;
  logic       out_free;

  assign stat = '{item_valid: item.valid, item_op: item.op, out_free: out_free};

  dda_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .stat       (stat),
    .item_ready (item.ready),
    .cmd        (cmd)
  );

  dda_datapath #(
    .FRAC_BITS (FRAC_BITS),
    .CELL_BITS (CELL_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .origin_x (item.origin_x),
    .origin_y (item.origin_y),
    .dir_x    (item.dir_x),
    .dir_y    (item.dir_y),
    .out_free (out_free),
    .result   (result)
  );

endmodule

/* hdl/dda_checker.sv */
// Port-level checks for the ray stepper, bound to the top level.
// Depends on dda_pkg and dda_grid_ray_stepper.
module dda_checker (
  input logic clk,
  input logic rst,
  input logic item_valid,
  input logic item_ready,
  input logic item_op,
  input logic result_valid,
  input logic result_ready
);
  import dda_pkg::*;

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result word dropped before it was taken");

  a_step_answer: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item_op == OP_STEP |=> result_valid)
    else $error("step word produced no result in the next cycle");

  a_init_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item_op == OP_INIT |=> !item_ready)
    else $error("new word taken while an init is in progress");

  a_init_quiet: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item_op == OP_INIT |=> !result_valid)
    else $error("result shown before the init finished");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |-> !item_ready)
    else $error("word taken while a result is stalled");

endmodule

bind dda_grid_ray_stepper dda_checker u_dda_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .item_op      (item.op),
  .result_valid (result.valid),
  .result_ready (result.ready)
);
